// ===== sv/cvsk_pkg.sv =====
// ----------------------------------------------------------------------------
// cvsk_pkg
// Shared types, register codes and constants of the shared-kernel convolver.
// ----------------------------------------------------------------------------
package cvsk_pkg;

  localparam int KG               = 4;   // kernel grid, taps per side
  localparam int MAX_STRIDE       = 4;
  localparam int SAMPLE_W         = 16;
  localparam int WEIGHT_W         = 8;
  localparam int VALUE_W          = 32;
  localparam int CH_OUT_W         = 4;
  localparam int POS_W            = 6;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int FIFO_DEPTH       = 8;
  localparam int PIPE_WINDOWS     = 4;   // window stages ahead of the result queue

  localparam int DEF_MAX_WIDTH        = 64;
  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 3'd6;

  typedef struct packed {
    logic [6:0]  input_size;
    logic [2:0]  field_size;
    logic [2:0]  stride;
    logic [4:0]  in_channels;
    logic [4:0]  out_channels;
    logic [63:0] weights_low;
    logic [63:0] weights_high;
  } cfg_t;

  typedef struct packed {
    logic             grid;
    logic             final_pos;
    logic [POS_W-1:0] orow;
    logic [POS_W-1:0] ocol;
  } pos_t;

  // v mod m for v < 4, m in 1..4
  function automatic logic [1:0] mod_small(input logic [1:0] v_in, input logic [2:0] m);
    logic [2:0] v;
    v = {1'b0, v_in};
    for (int i = 0; i < 3; i++) begin
      if (v >= m) v = v - m;
    end
    return v[1:0];
  endfunction

endpackage

// ===== sv/cvsk_if.sv =====
// ----------------------------------------------------------------------------
// cvsk interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cvsk_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cvsk_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface cvsk_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvsk_pkg::VALUE_W-1:0] conv_value;
  logic [cvsk_pkg::CH_OUT_W-1:0]       out_channel;
  logic [cvsk_pkg::POS_W-1:0]          out_row;
  logic [cvsk_pkg::POS_W-1:0]          out_col;
  logic                                last;
  logic                                frame_end;
  modport source (output valid, output conv_value, output out_channel, output out_row,
                  output out_col, output last, output frame_end, input ready);
  modport sink   (input valid, input conv_value, input out_channel, input out_row,
                  input out_col, input last, input frame_end, output ready);
endinterface

interface cvsk_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cvsk_pkg::CFG_IDX_W-1:0]    index;
  logic [cvsk_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/cvsk_ram.sv =====
// ----------------------------------------------------------------------------
// cvsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cvsk_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cvsk_front.sv =====
// ----------------------------------------------------------------------------
// cvsk_front
// Config registers, channel sum, raster counters, line store and window.
// ----------------------------------------------------------------------------
module cvsk_front #(
  parameter int MAX_WIDTH       = cvsk_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CHANNELS = cvsk_pkg::DEF_MAX_IN_CHANNELS,
  parameter int SUMW            = cvsk_pkg::SAMPLE_W + $clog2(MAX_IN_CHANNELS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cvsk_cfg_if.sink               cfg_i,
  cvsk_sample_if.sink            sample_i,
  input  logic                   allow_i,
  output cvsk_pkg::cfg_t         cfg_o,
  output logic [2:0]             field_o,
  output logic signed [SUMW-1:0] win_o [cvsk_pkg::KG][cvsk_pkg::KG],
  output cvsk_pkg::pos_t         pos_o,
  output logic                   pos_vld_o
);

  localparam int KG  = cvsk_pkg::KG;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SW  = $clog2(MAX_WIDTH + 1);
  localparam int ICW = $clog2(MAX_IN_CHANNELS + 1);
  localparam int CHW = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int PW  = (CW > cvsk_pkg::POS_W) ? CW : cvsk_pkg::POS_W;
  localparam int RW  = KG * SUMW;

  cvsk_pkg::cfg_t cfg_q;
  logic           restart;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    case (cfg_i.index)
      cvsk_pkg::REG_INPUT_SIZE, cvsk_pkg::REG_FIELD_SIZE, cvsk_pkg::REG_STRIDE,
      cvsk_pkg::REG_IN_CHANNELS, cvsk_pkg::REG_OUT_CHANNELS,
      cvsk_pkg::REG_WEIGHTS_LOW, cvsk_pkg::REG_WEIGHTS_HIGH: restart = cfg_i.valid;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_size   <= 7'd8;
      cfg_q.field_size   <= 3'd3;
      cfg_q.stride       <= 3'd1;
      cfg_q.in_channels  <= 5'd1;
      cfg_q.out_channels <= 5'd1;
      cfg_q.weights_low  <= '0;
      cfg_q.weights_high <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cvsk_pkg::REG_INPUT_SIZE:   cfg_q.input_size   <= cfg_i.data[6:0];
        cvsk_pkg::REG_FIELD_SIZE:   cfg_q.field_size   <= cfg_i.data[2:0];
        cvsk_pkg::REG_STRIDE:       cfg_q.stride       <= cfg_i.data[2:0];
        cvsk_pkg::REG_IN_CHANNELS:  cfg_q.in_channels  <= cfg_i.data[4:0];
        cvsk_pkg::REG_OUT_CHANNELS: cfg_q.out_channels <= cfg_i.data[4:0];
        cvsk_pkg::REG_WEIGHTS_LOW:  cfg_q.weights_low  <= cfg_i.data;
        cvsk_pkg::REG_WEIGHTS_HIGH: cfg_q.weights_high <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [SW-1:0]  sz;
  logic [2:0]     fcl;
  logic [2:0]     st;
  logic [ICW-1:0] ic;
  logic [1:0]     tmod;

  always_comb begin
    if (cfg_q.input_size == 7'd0)                 sz = SW'(1);
    else if (32'(cfg_q.input_size) > MAX_WIDTH)   sz = SW'(MAX_WIDTH);
    else                                          sz = SW'(cfg_q.input_size);
    if (cfg_q.field_size == 3'd0)                 fcl = 3'd1;
    else if (32'(cfg_q.field_size) > KG)          fcl = 3'(KG);
    else                                          fcl = cfg_q.field_size;
    if (cfg_q.stride == 3'd0)                     st = 3'd1;
    else if (32'(cfg_q.stride) > cvsk_pkg::MAX_STRIDE) st = 3'(cvsk_pkg::MAX_STRIDE);
    else                                          st = cfg_q.stride;
    if (cfg_q.in_channels == 5'd0)                ic = ICW'(1);
    else if (32'(cfg_q.in_channels) > MAX_IN_CHANNELS) ic = ICW'(MAX_IN_CHANNELS);
    else                                          ic = ICW'(cfg_q.in_channels);
  end

  assign tmod    = cvsk_pkg::mod_small(2'(fcl - 3'd1), st);
  assign field_o = fcl;

  // stage A: accumulate channels, walk the raster
  logic signed [SUMW-1:0] csum_q, csum_d, sum_next;
  logic [CHW-1:0]         ch_q, ch_d;
  logic [CW-1:0]          col_q, col_d, row_q, row_d, ocol_q, ocol_d, orow_q, orow_d;
  logic [1:0]             cph_q, cph_d, rph_q, rph_d;
  logic                   accept, last_ch, pix, col_end, row_end, col_ok, row_ok;
  logic [1:0]             cph_inc, rph_inc;
  cvsk_pkg::pos_t         pos_a;
  logic [PW-1:0]          ocol_x, orow_x;

  assign sample_i.ready = allow_i;
  assign accept   = sample_i.valid && allow_i;
  assign sum_next = csum_q + SUMW'(sample_i.sample);
  assign last_ch  = (32'(ch_q) + 32'd1) >= 32'(ic);
  assign pix      = accept && last_ch;
  assign col_end  = (32'(col_q) + 32'd1) >= 32'(sz);
  assign row_end  = (32'(row_q) + 32'd1) >= 32'(sz);
  assign cph_inc  = ((3'(cph_q) + 3'd1) >= st) ? 2'd0 : 2'(cph_q + 2'd1);
  assign rph_inc  = ((3'(rph_q) + 3'd1) >= st) ? 2'd0 : 2'(rph_q + 2'd1);
  assign col_ok   = ((32'(col_q) + 32'd1) >= 32'(fcl)) && (cph_q == tmod);
  assign row_ok   = ((32'(row_q) + 32'd1) >= 32'(fcl)) && (rph_q == tmod);
  assign ocol_x   = PW'(ocol_q);
  assign orow_x   = PW'(orow_q);

  always_comb begin
    pos_a.grid      = (32'(fcl) <= 32'(sz)) && col_ok && row_ok;
    pos_a.final_pos = ((32'(col_q) + 32'(st)) >= 32'(sz)) &&
                      ((32'(row_q) + 32'(st)) >= 32'(sz));
    pos_a.orow      = orow_x[cvsk_pkg::POS_W-1:0];
    pos_a.ocol      = ocol_x[cvsk_pkg::POS_W-1:0];
  end

  always_comb begin
    csum_d = csum_q; ch_d = ch_q; col_d = col_q; row_d = row_q;
    cph_d = cph_q; rph_d = rph_q; ocol_d = ocol_q; orow_d = orow_q;
    if (restart) begin
      csum_d = '0; ch_d = '0; col_d = '0; row_d = '0;
      cph_d = '0; rph_d = '0; ocol_d = '0; orow_d = '0;
    end else if (accept) begin
      csum_d = last_ch ? '0 : sum_next;
      ch_d   = last_ch ? '0 : CHW'(ch_q + 1'b1);
      if (last_ch) begin
        if (col_end) begin
          col_d  = '0;
          cph_d  = '0;
          ocol_d = '0;
          row_d  = row_end ? '0 : CW'(row_q + 1'b1);
          rph_d  = row_end ? 2'd0 : rph_inc;
          orow_d = row_end ? '0 : (row_ok ? CW'(orow_q + 1'b1) : orow_q);
        end else begin
          col_d  = CW'(col_q + 1'b1);
          cph_d  = cph_inc;
          ocol_d = col_ok ? CW'(ocol_q + 1'b1) : ocol_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0; ch_q <= '0; col_q <= '0; row_q <= '0;
      cph_q <= '0; rph_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else begin
      csum_q <= csum_d; ch_q <= ch_d; col_q <= col_d; row_q <= row_d;
      cph_q <= cph_d; rph_q <= rph_d; ocol_q <= ocol_d; orow_q <= orow_d;
    end
  end

  // line store: one word per column, one slot per row modulo KG
  logic                   s1_vld_q;
  logic signed [SUMW-1:0] s1_sum_q;
  logic [1:0]             s1_slot_q;
  logic [CW-1:0]          s1_col_q;
  cvsk_pkg::pos_t         s1_pos_q;
  logic [RW-1:0]          rdata, old_word, wdata, byp_data_q;
  logic                   byp_q;

  cvsk_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      s1_vld_q <= pix;
      byp_q    <= s1_vld_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
    if (pix) begin
      s1_sum_q  <= sum_next;
      s1_slot_q <= row_q[1:0];
      s1_col_q  <= col_q;
      s1_pos_q  <= pos_a;
    end
  end

  // stage B: merge the new sum, shift the window
  logic signed [SUMW-1:0] cv [KG];
  logic [1:0]             fm1;
  logic signed [SUMW-1:0] win_q [KG][KG];
  logic                   pos_vld_q;
  cvsk_pkg::pos_t         pos_q;

  assign old_word = byp_q ? byp_data_q : rdata;
  assign fm1      = 2'(fcl - 3'd1);

  always_comb begin
    for (int s = 0; s < KG; s++) begin
      wdata[s*SUMW +: SUMW] = (2'(s) == s1_slot_q) ? s1_sum_q : old_word[s*SUMW +: SUMW];
    end
    for (int r = 0; r < KG; r++) begin
      cv[r] = wdata[(2'(s1_slot_q + 2'(r) - fm1))*SUMW +: SUMW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int r = 0; r < KG; r++) begin
        for (int c = 0; c < KG - 1; c++) win_q[r][c] <= win_q[r][c+1];
        win_q[r][KG-1] <= cv[r];
      end
      pos_q <= s1_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_vld_q <= 1'b0;
    else         pos_vld_q <= s1_vld_q && s1_pos_q.grid;
  end

  assign win_o     = win_q;
  assign pos_o     = pos_q;
  assign pos_vld_o = pos_vld_q;

endmodule

// ===== sv/cvsk_mac.sv =====
// ----------------------------------------------------------------------------
// cvsk_mac
// Tap products, row sums and window total for one completed window.
// ----------------------------------------------------------------------------
module cvsk_mac #(
  parameter int SUMW = cvsk_pkg::SAMPLE_W + 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cvsk_pkg::cfg_t                        cfg_i,
  input  logic [2:0]                            field_i,
  input  logic signed [SUMW-1:0]                win_i [cvsk_pkg::KG][cvsk_pkg::KG],
  input  cvsk_pkg::pos_t                        pos_i,
  input  logic                                  pos_vld_i,
  output logic                                  push_o,
  output logic signed [cvsk_pkg::VALUE_W-1:0]   value_o,
  output cvsk_pkg::pos_t                        pos_o
);

  localparam int KG  = cvsk_pkg::KG;
  localparam int PRW = SUMW + cvsk_pkg::WEIGHT_W;
  localparam int RSW = PRW + 2;
  localparam int AW  = PRW + 4;

  logic [127:0]          wall;
  logic signed [PRW-1:0] prod_q [KG][KG];
  logic signed [RSW-1:0] rsum_q [KG];
  logic                  s3_vld_q, s4_vld_q;
  cvsk_pkg::pos_t        s3_pos_q, s4_pos_q;
  logic signed [AW-1:0]  total;
  logic signed [63:0]    total_x;

  assign wall = {cfg_i.weights_high, cfg_i.weights_low};

  always_ff @(posedge clk_i) begin
    if (pos_vld_i) begin
      for (int r = 0; r < KG; r++) begin
        for (int c = 0; c < KG; c++) begin
          if ((r < 32'(field_i)) && (c < 32'(field_i))) begin
            prod_q[r][c] <= PRW'(win_i[r][2'(3'(KG) - field_i + 3'(c))]) *
                            PRW'($signed(wall[8*(4*r+c) +: 8]));
          end else begin
            prod_q[r][c] <= '0;
          end
        end
      end
      s3_pos_q <= pos_i;
    end
    if (s3_vld_q) begin
      for (int r = 0; r < KG; r++) begin
        rsum_q[r] <= RSW'(prod_q[r][0]) + RSW'(prod_q[r][1]) +
                     RSW'(prod_q[r][2]) + RSW'(prod_q[r][3]);
      end
      s4_pos_q <= s3_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= pos_vld_i;
      s4_vld_q <= s3_vld_q;
    end
  end

  assign total   = AW'(rsum_q[0]) + AW'(rsum_q[1]) + AW'(rsum_q[2]) + AW'(rsum_q[3]);
  assign total_x = 64'(total);
  assign value_o = total_x[cvsk_pkg::VALUE_W-1:0];
  assign push_o  = s4_vld_q;
  assign pos_o   = s4_pos_q;

endmodule

// ===== sv/cvsk_outq.sv =====
// ----------------------------------------------------------------------------
// cvsk_outq
// Result queue; each window is sent once per output channel.
// ----------------------------------------------------------------------------
module cvsk_outq #(
  parameter int MAX_OUT_CHANNELS = cvsk_pkg::DEF_MAX_OUT_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [cvsk_pkg::VALUE_W-1:0] value_i,
  input  cvsk_pkg::pos_t                      pos_i,
  input  logic [4:0]                          out_channels_i,
  output logic [$clog2(cvsk_pkg::FIFO_DEPTH+1)-1:0] count_o,
  cvsk_result_if.source                       result_o
);

  localparam int DEPTH = cvsk_pkg::FIFO_DEPTH;
  localparam int FAW   = $clog2(DEPTH);
  localparam int FCW   = $clog2(DEPTH + 1);
  localparam int OCW   = $clog2(MAX_OUT_CHANNELS + 1);
  localparam int KW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int XW    = (KW > cvsk_pkg::CH_OUT_W) ? KW : cvsk_pkg::CH_OUT_W;

  logic signed [cvsk_pkg::VALUE_W-1:0] val_q [DEPTH];
  cvsk_pkg::pos_t                      pos_q [DEPTH];
  logic [FAW-1:0]                      wp_q, rp_q;
  logic [FCW-1:0]                      cnt_q;
  logic [KW-1:0]                       k_q;
  logic [OCW-1:0]                      oc;
  logic [XW-1:0]                       k_x;
  logic                                fire, lastc, pop;
  cvsk_pkg::pos_t                      head;

  always_comb begin
    if (out_channels_i == 5'd0)                       oc = OCW'(1);
    else if (32'(out_channels_i) > MAX_OUT_CHANNELS)  oc = OCW'(MAX_OUT_CHANNELS);
    else                                              oc = OCW'(out_channels_i);
  end

  assign head  = pos_q[rp_q];
  assign lastc = (32'(k_q) + 32'd1) >= 32'(oc);
  assign fire  = result_o.valid && result_o.ready;
  assign pop   = fire && lastc;
  assign k_x   = XW'(k_q);

  assign result_o.valid       = (cnt_q != '0);
  assign result_o.conv_value  = val_q[rp_q];
  assign result_o.out_channel = k_x[cvsk_pkg::CH_OUT_W-1:0];
  assign result_o.out_row     = head.orow;
  assign result_o.out_col     = head.ocol;
  assign result_o.last        = lastc;
  assign result_o.frame_end   = lastc && head.final_pos;
  assign count_o              = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      val_q[wp_q] <= value_i;
      pos_q[wp_q] <= pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      if (push_i) wp_q <= FAW'(wp_q + 1'b1);
      if (pop)    rp_q <= FAW'(rp_q + 1'b1);
      cnt_q <= FCW'(cnt_q + FCW'(push_i) - FCW'(pop));
      if (fire)   k_q <= lastc ? '0 : KW'(k_q + 1'b1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH) else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (32'(cnt_q) == DEPTH)) |-> pop) else $error("push into full queue");

  a_copy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=> $stable(k_q) && $stable(rp_q))
    else $error("copy index moved while stalled");

endmodule

// ===== sv/conv2d_shared_kernel_stream.sv =====
// ----------------------------------------------------------------------------
// conv2d_shared_kernel_stream
// Strided valid 2D convolution, one kernel shared by all channels.
//
//  channel   dir  word                               accepted when
//  sample_i  in   sample (Q8.8)                      valid && ready
//  cfg_i     in   index, data                        valid && ready (ready = 1)
//  result_o  out  conv_value, out_channel, row, col,  valid && ready
//                 last, frame_end
//
// One sample per cycle while sample_i.ready is high. A completed window
// passes the line store read, window shift, products and row sums
// registers into the result queue; its first word is offered once it
// reaches the queue head. Each window is sent out_channels times, one word
// per cycle while result_o.ready is high. sample_i.ready drops while the
// result queue could not absorb the windows still in the pipeline. Reset
// clears counters and queue; the line store needs no clearing.
// ----------------------------------------------------------------------------
module conv2d_shared_kernel_stream #(
  parameter int MAX_WIDTH        = cvsk_pkg::DEF_MAX_WIDTH,
  parameter int MAX_IN_CHANNELS  = cvsk_pkg::DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = cvsk_pkg::DEF_MAX_OUT_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cvsk_cfg_if.sink      cfg_i,
  cvsk_sample_if.sink   sample_i,
  cvsk_result_if.source result_o
);

  localparam int SUMW = cvsk_pkg::SAMPLE_W + $clog2(MAX_IN_CHANNELS);
  localparam int KG   = cvsk_pkg::KG;

  cvsk_pkg::cfg_t                      cfg;
  logic [2:0]                          field;
  logic signed [SUMW-1:0]              win [KG][KG];
  cvsk_pkg::pos_t                      win_pos, res_pos;
  logic                                win_vld, push, allow;
  logic signed [cvsk_pkg::VALUE_W-1:0] value;
  logic [$clog2(cvsk_pkg::FIFO_DEPTH+1)-1:0] count;

  assign allow = (32'(count) + cvsk_pkg::PIPE_WINDOWS + 1) <= cvsk_pkg::FIFO_DEPTH;

  cvsk_front #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .SUMW            (SUMW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .sample_i  (sample_i),
    .allow_i   (allow),
    .cfg_o     (cfg),
    .field_o   (field),
    .win_o     (win),
    .pos_o     (win_pos),
    .pos_vld_o (win_vld)
  );

  cvsk_mac #(.SUMW(SUMW)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .field_i   (field),
    .win_i     (win),
    .pos_i     (win_pos),
    .pos_vld_i (win_vld),
    .push_o    (push),
    .value_o   (value),
    .pos_o     (res_pos)
  );

  cvsk_outq #(.MAX_OUT_CHANNELS(MAX_OUT_CHANNELS)) u_outq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .value_i        (value),
    .pos_i          (res_pos),
    .out_channels_i (cfg.out_channels),
    .count_o        (count),
    .result_o       (result_o)
  );

endmodule
